>>> hdl/assert_macros.svh
// assertion macros shared by the queue modules
// each expects clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle
`define DRF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// property that must hold in the next cycle
`define DRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/drf_pkg.sv
package drf_pkg;

  // operation codes
  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;

  // result status codes
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_BAD_PORT  = 3'd3;
  localparam logic [2:0] ST_POPPED    = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] peer_address;
    logic [15:0] peer_port;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_address;
    logic [15:0] out_port;
    logic        now_empty;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_push;
    logic empty;
    logic scan_last;
    logic match;
    logic out_free;
  } ctrl_sts_t;

endpackage

>>> hdl/drf_ctrl.sv
`include "assert_macros.svh"

module drf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  drf_pkg::ctrl_sts_t  sts,
  output drf_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          // a push against live entries has to scan them first
          if (sts.in_push && !sts.empty) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.match || sts.scan_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for room in the output register
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `DRF_ASSERT_NOW(a_finish_room, cmd.finish, sts.out_free, "result committed while output busy")
  `DRF_ASSERT_NEXT(a_scan_exit, state == S_SCAN, state == S_SCAN || state == S_FINISH, "scan left to wrong state")
  `DRF_ASSERT_NEXT(a_load_busy, cmd.load, !in_ready, "second beat taken before finish")

endmodule

>>> hdl/drf_datapath.sv
`include "assert_macros.svh"

module drf_datapath #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  drf_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output drf_pkg::out_beat_t  out_data,
  input  drf_pkg::ctrl_cmd_t  cmd,
  output drf_pkg::ctrl_sts_t  sts
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // ring store
  drf_pkg::entry_t mem [DEPTH];
  drf_pkg::entry_t rd_data;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;

  logic [IdxW-1:0] head;
  logic [IdxW-1:0] tail;
  logic [IdxW-1:0] head_next;
  logic [IdxW-1:0] tail_next;
  logic [IdxW-1:0] scan_ptr;
  drf_pkg::in_beat_t  req;
  logic               dup;
  drf_pkg::out_beat_t res;

  function automatic logic [IdxW-1:0] next_slot(input logic [IdxW-1:0] i);
    if (i == IdxW'(DEPTH - 1)) begin
      return '0;
    end else begin
      return i + IdxW'(1);
    end
  endfunction

  // status towards the controller
  assign sts.in_push   = (in_data.kind == drf_pkg::KIND_PUSH);
  assign sts.empty     = (head == tail);
  assign sts.scan_last = (scan_ptr == tail);
  assign sts.match     = (rd_data.addr == req.peer_address) && (rd_data.port == req.peer_port);
  assign sts.out_free  = !out_valid || out_ready;

  // read port: head on load, next live slot while scanning
  always_comb begin
    rd_en   = cmd.load || (cmd.scan && !sts.scan_last);
    rd_addr = cmd.load ? head : scan_ptr;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= '{addr: req.peer_address, port: req.peer_port};
    end
  end

  // request capture and scan progress
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req      <= in_data;
      dup      <= 1'b0;
      scan_ptr <= next_slot(head);
    end else if (cmd.scan) begin
      if (sts.match) begin
        dup <= 1'b1;
      end
      if (!sts.scan_last) begin
        scan_ptr <= next_slot(scan_ptr);
      end
    end
  end

  // result and pointer update
  always_comb begin
    head_next       = head;
    tail_next       = tail;
    wr_en           = 1'b0;
    res             = '0;
    if (req.kind[1]) begin
      head_next  = '0;
      tail_next  = '0;
      res.status = drf_pkg::ST_CLEARED;
    end else if (req.kind == drf_pkg::KIND_POP) begin
      if (head == tail) begin
        res.status = drf_pkg::ST_EMPTY;
      end else begin
        res.status      = drf_pkg::ST_POPPED;
        res.out_address = rd_data.addr;
        res.out_port    = rd_data.port;
        head_next       = next_slot(head);
      end
    end else begin
      priority if (dup) begin
        res.status = drf_pkg::ST_DUPLICATE;
      end else if (next_slot(tail) == head) begin
        res.status = drf_pkg::ST_FULL;
      end else if (req.peer_port == '0) begin
        res.status = drf_pkg::ST_BAD_PORT;
      end else begin
        res.status = drf_pkg::ST_ADDED;
        wr_en      = cmd.finish;
        tail_next  = next_slot(tail);
      end
    end
    res.now_empty = (head_next == tail_next);
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else if (cmd.finish) begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= res;
    end
  end

  `DRF_ASSERT_NOW(a_ptr_range, 1'b1, head <= IdxW'(DEPTH - 1) && tail <= IdxW'(DEPTH - 1), "pointer out of ring")
  `DRF_ASSERT_NOW(a_scan_live, cmd.scan, head != tail, "scan on an empty queue")
  `DRF_ASSERT_NEXT(a_add_live, cmd.finish && res.status == drf_pkg::ST_ADDED, head != tail, "added entry not live")

endmodule

>>> hdl/dedup_ring_fifo_top.sv
// channel  dir  handshake           payload
// in       in   in_valid/in_ready   kind, peer_address, peer_port
// out      out  out_valid/out_ready status, out_address, out_port, now_empty
//
// push: one compare per cycle over the live entries, through
//   the single read port of the ring store; pop and clear skip the scan
// next beat is taken once the previous result sits in the output register
// reset clears head, tail and the controller; ring contents are not cleared
// a stalled output holds the finished result; the block waits before committing
module dedup_ring_fifo_top #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  drf_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output drf_pkg::out_beat_t out_data
);

  drf_pkg::ctrl_cmd_t cmd;
  drf_pkg::ctrl_sts_t sts;

  // sequencer
  drf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // ring store, pointers and result register
  drf_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> dv/tb_dedup_ring_fifo_top.sv
module tb_dedup_ring_fifo_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_BEATS = 1330;
  localparam int NUM_STATUS = 7;

  // the package names push and pop only; both upper codes clear the ring
  localparam logic [1:0] KIND_CLEAR     = 2'd2;
  localparam logic [1:0] KIND_CLEAR_ALT = 2'd3;

  // idling per phase: no idling, sender idle, receiver stalling, both
  localparam int unsigned NUM_PHASES = 4;
  localparam int unsigned SEND_IDLE[NUM_PHASES] = '{0, 85, 0, 28};
  localparam int unsigned RECV_STALL[NUM_PHASES] = '{0, 0, 85, 28};

  // tracks ring contents and the queue of awaited outcomes
  class ring_tracker;
    logic [31:0]         addr_ring[DEPTH];
    logic [15:0]         port_ring[DEPTH];
    int unsigned         head_idx;
    int unsigned         tail_idx;
    drf_pkg::out_beat_t  awaited[$];
    int unsigned         failures;
    int unsigned         beats_in;
    int unsigned         status_seen[NUM_STATUS];

    function new();
      head_idx = 0;
      tail_idx = 0;
      failures = 0;
      beats_in = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned live_count();
      return (tail_idx + DEPTH - head_idx) % DEPTH;
    endfunction

    function drf_pkg::entry_t live_entry(int unsigned k);
      drf_pkg::entry_t e;
      int unsigned slot;
      slot = (head_idx + k) % DEPTH;
      e.addr = addr_ring[slot];
      e.port = port_ring[slot];
      return e;
    endfunction

    // expected outcome of one beat, updating the ring
    function drf_pkg::out_beat_t predict_outcome(drf_pkg::in_beat_t req);
      drf_pkg::out_beat_t res;
      bit                 dup;
      int unsigned        slot;
      res = '0;
      dup = 1'b0;
      if (req.kind[1]) begin
        head_idx = 0;
        tail_idx = 0;
        res.status = drf_pkg::ST_CLEARED;
      end else if (req.kind == drf_pkg::KIND_POP) begin
        if (head_idx == tail_idx) begin
          res.status = drf_pkg::ST_EMPTY;
        end else begin
          res.out_address = addr_ring[head_idx];
          res.out_port = port_ring[head_idx];
          head_idx = (head_idx + 1) % DEPTH;
          res.status = drf_pkg::ST_POPPED;
        end
      end else begin
        // duplicate scan over live entries, head to tail
        slot = head_idx;
        while (slot != tail_idx) begin
          if (addr_ring[slot] == req.peer_address && port_ring[slot] == req.peer_port)
            dup = 1'b1;
          slot = (slot + 1) % DEPTH;
        end
        if (dup) begin
          res.status = drf_pkg::ST_DUPLICATE;
        end else if ((tail_idx + 1) % DEPTH == head_idx) begin
          res.status = drf_pkg::ST_FULL;
        end else if (req.peer_port == 16'd0) begin
          res.status = drf_pkg::ST_BAD_PORT;
        end else begin
          addr_ring[tail_idx] = req.peer_address;
          port_ring[tail_idx] = req.peer_port;
          tail_idx = (tail_idx + 1) % DEPTH;
          res.status = drf_pkg::ST_ADDED;
        end
      end
      res.now_empty = (head_idx == tail_idx);
      return res;
    endfunction

    function void note_request(drf_pkg::in_beat_t req);
      drf_pkg::out_beat_t res;
      res = predict_outcome(req);
      awaited.push_back(res);
      beats_in++;
      status_seen[res.status]++;
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    function void check_outcome(drf_pkg::out_beat_t got);
      drf_pkg::out_beat_t want;
      if (awaited.size() == 0) begin
        failures++;
        $display("%0t: result with nothing awaited, got status %0d addr %0h port %0h empty %0b",
                 $time, got.status, got.out_address, got.out_port, got.now_empty);
      end else begin
        want = awaited.pop_front();
        compare_field("status", 32'(want.status), 32'(got.status));
        compare_field("out_address", want.out_address, got.out_address);
        compare_field("out_port", 32'(want.out_port), 32'(got.out_port));
        compare_field("now_empty", 32'(want.now_empty), 32'(got.now_empty));
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  drf_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  drf_pkg::out_beat_t out_data;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  ring_tracker tracker;

  dedup_ring_fifo_top #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // clock
  always #4 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // beat monitors: outcome check first, then the new request
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_outcome(out_data);
    if (!rst && in_valid && in_ready) tracker.note_request(in_data);
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d outcomes still awaited",
               $time, IDLE_LIMIT, tracker.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // present one beat, with random idle cycles ahead of it
  task automatic send_beat(input drf_pkg::in_beat_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_fields(input logic [1:0] kind, input logic [31:0] addr,
                             input logic [15:0] port);
    drf_pkg::in_beat_t req;
    req.kind = kind;
    req.peer_address = addr;
    req.peer_port = port;
    send_beat(req);
  endtask

  // random beat; rates in parts per thousand
  function automatic drf_pkg::in_beat_t make_beat(int unsigned push_pm, int unsigned clear_pm);
    drf_pkg::in_beat_t req;
    drf_pkg::entry_t   e;
    int unsigned       r;
    int unsigned       v;
    int unsigned       live;
    req.kind = drf_pkg::KIND_POP;
    req.peer_address = $urandom();
    req.peer_port = 16'($urandom());
    live = tracker.live_count();
    r = $urandom_range(0, 999);
    if (r < clear_pm) begin
      req.kind = $urandom_range(0, 1) ? KIND_CLEAR : KIND_CLEAR_ALT;
    end else if (r < clear_pm + push_pm) begin
      req.kind = drf_pkg::KIND_PUSH;
      v = $urandom_range(0, 99);
      if (v < 15 && live > 0) begin
        // exact copy of a live entry
        e = tracker.live_entry($urandom_range(0, live - 1));
        req.peer_address = e.addr;
        req.peer_port = e.port;
      end else if (v < 20) begin
        req.peer_port = 16'd0;
      end else if (v < 25 && live > 0) begin
        // same address as a live entry, fresh port
        e = tracker.live_entry($urandom_range(0, live - 1));
        req.peer_address = e.addr;
      end else if (v < 28) begin
        req.peer_address = 32'h0;
      end else if (v < 31) begin
        req.peer_address = 32'hFFFF_FFFF;
      end else if (v < 34) begin
        req.peer_port = 16'hFFFF;
      end
    end
    return req;
  endfunction

  // segments that fill, drain or mix, so the ring reaches full and empty
  task automatic run_phase(input int unsigned n_beats);
    int unsigned sent;
    int unsigned seg_left;
    int unsigned push_pm;
    int unsigned clear_pm;
    sent = 0;
    seg_left = 0;
    push_pm = 550;
    clear_pm = 30;
    while (sent < n_beats) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 120);
        case ($urandom_range(0, 2))
          0: begin
            push_pm = 960;
            clear_pm = 3;
          end
          1: begin
            push_pm = 150;
            clear_pm = 20;
          end
          default: begin
            push_pm = 550;
            clear_pm = 30;
          end
        endcase
      end
      send_beat(make_beat(push_pm, clear_pm));
      sent++;
      seg_left--;
    end
  endtask

  initial begin
    tracker = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pop, port zero, extremes, duplicates, both clear codes
    send_fields(drf_pkg::KIND_POP,  32'h0,         16'h0);
    send_fields(drf_pkg::KIND_PUSH, 32'h0,         16'h0);
    send_fields(drf_pkg::KIND_PUSH, 32'hFFFF_FFFF, 16'hFFFF);
    send_fields(drf_pkg::KIND_PUSH, 32'hFFFF_FFFF, 16'hFFFF);
    send_fields(drf_pkg::KIND_PUSH, 32'hFFFF_FFFF, 16'h0001);
    send_fields(drf_pkg::KIND_PUSH, 32'h0,         16'hFFFF);
    send_fields(drf_pkg::KIND_PUSH, 32'h0,         16'h0);
    send_fields(drf_pkg::KIND_PUSH, 32'h0,         16'hFFFF);
    send_fields(drf_pkg::KIND_POP,  32'hFFFF_FFFF, 16'hFFFF);
    send_fields(drf_pkg::KIND_PUSH, 32'hFFFF_FFFF, 16'hFFFF);
    send_fields(drf_pkg::KIND_PUSH, 32'h0000_0001, 16'h8000);
    send_fields(KIND_CLEAR_ALT,     32'hFFFF_FFFF, 16'hFFFF);
    send_fields(drf_pkg::KIND_POP,  32'h0,         16'h0);
    send_fields(drf_pkg::KIND_PUSH, 32'h1234_5678, 16'h8001);
    send_fields(drf_pkg::KIND_PUSH, 32'h8000_0000, 16'h0001);
    send_fields(KIND_CLEAR,         32'hA5A5_A5A5, 16'h5A5A);
    send_fields(drf_pkg::KIND_PUSH, 32'hA5A5_A5A5, 16'h5A5A);
    send_fields(drf_pkg::KIND_PUSH, 32'h5A5A_5A5A, 16'hA5A5);
    send_fields(drf_pkg::KIND_POP,  32'h0,         16'h0);
    send_fields(drf_pkg::KIND_POP,  32'h0,         16'h0);
    send_fields(drf_pkg::KIND_POP,  32'h0,         16'h0);
    send_fields(KIND_CLEAR,         32'h0,         16'h0);

    // random phases under each idling pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = SEND_IDLE[p];
      stall_pct = RECV_STALL[p];
      run_phase(RANDOM_BEATS / NUM_PHASES);
    end
    in_valid <= 1'b0;

    // drain, then allow for a late stray result
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    $display("%0d beats checked across four idling phases", tracker.beats_in);
    $display("added %0d, duplicate %0d, full %0d, bad port %0d, popped %0d, empty %0d",
             tracker.status_seen[drf_pkg::ST_ADDED], tracker.status_seen[drf_pkg::ST_DUPLICATE],
             tracker.status_seen[drf_pkg::ST_FULL], tracker.status_seen[drf_pkg::ST_BAD_PORT],
             tracker.status_seen[drf_pkg::ST_POPPED], tracker.status_seen[drf_pkg::ST_EMPTY]);
    if (tracker.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
